// ===== sv/plhf_pkg.sv =====
package plhf_pkg;

	localparam int PRODUCER_ID_BITS_DEF = 8;
	localparam int ID_IN_W  = 8;
	localparam int GEN_W    = 32;
	localparam int FUNC_W   = 3;
	localparam int STATE_W  = 2;
	localparam int STATUS_W = 2;

	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 72;

	// Operation codes
	localparam logic [FUNC_W-1:0] FN_ACTIVATE      = 3'd0;
	localparam logic [FUNC_W-1:0] FN_START_HANDOFF = 3'd1;
	localparam logic [FUNC_W-1:0] FN_COMMIT        = 3'd2;
	localparam logic [FUNC_W-1:0] FN_ABORT         = 3'd3;
	localparam logic [FUNC_W-1:0] FN_FAULT         = 3'd4;
	localparam logic [FUNC_W-1:0] FN_BEGIN_RECOVER = 3'd5;
	localparam logic [FUNC_W-1:0] FN_RECOVER       = 3'd6;
	localparam logic [FUNC_W-1:0] FN_VALIDATE      = 3'd7;

	// Lease states
	localparam logic [STATE_W-1:0] ST_EMPTY   = 2'd0;
	localparam logic [STATE_W-1:0] ST_ACTIVE  = 2'd1;
	localparam logic [STATE_W-1:0] ST_HANDOFF = 2'd2;
	localparam logic [STATE_W-1:0] ST_FAULT   = 2'd3;

	// Status codes
	localparam logic [STATUS_W-1:0] RC_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] RC_ARG   = 2'd1;
	localparam logic [STATUS_W-1:0] RC_STATE = 2'd2;

	typedef struct packed {
		logic [GEN_W-1:0]    pending_gen;
		logic [STATE_W-1:0]  lease_state;
		logic                is_valid;
		logic [GEN_W-1:0]    gen;
		logic [STATUS_W-1:0] status;
	} result_t;

	// Generations advance by one, wrap and never land on zero.
	function automatic logic [GEN_W-1:0] gen_advance(input logic [GEN_W-1:0] g);
		logic [GEN_W-1:0] n;
		n = g + GEN_W'(1);
		gen_advance = (n == '0) ? GEN_W'(1) : n;
	endfunction

endpackage

// ===== sv/plhf_step.sv =====
module plhf_step #(
	parameter int ID_W = plhf_pkg::PRODUCER_ID_BITS_DEF
) (
	input  logic [plhf_pkg::FUNC_W-1:0]  func,
	input  logic [ID_W-1:0]              prod,
	input  logic [ID_W-1:0]              nxt,
	input  logic [plhf_pkg::GEN_W-1:0]   gin,
	input  logic [plhf_pkg::STATE_W-1:0] state_q,
	input  logic [plhf_pkg::GEN_W-1:0]   cur_gen_q,
	input  logic [ID_W-1:0]              owner_q,
	input  logic [ID_W-1:0]              incoming_q,
	input  logic [plhf_pkg::GEN_W-1:0]   reserved_q,
	output logic [plhf_pkg::STATE_W-1:0] state_d,
	output logic [plhf_pkg::GEN_W-1:0]   cur_gen_d,
	output logic [ID_W-1:0]              owner_d,
	output logic [ID_W-1:0]              incoming_d,
	output logic [plhf_pkg::GEN_W-1:0]   reserved_d,
	output plhf_pkg::result_t            result
);

	logic                       pair_ok;
	logic [plhf_pkg::GEN_W-1:0] gen_next;

	assign gen_next = plhf_pkg::gen_advance(cur_gen_q);

	// In handoff the pending pair is the one that counts.
	always_comb begin
		pair_ok = 1'b0;
		if (prod != '0) begin
			if (state_q == plhf_pkg::ST_ACTIVE) begin
				pair_ok = (owner_q == prod) && (cur_gen_q == gin);
			end else if (state_q == plhf_pkg::ST_HANDOFF) begin
				pair_ok = (incoming_q == prod) && (reserved_q == gin);
			end
		end
	end

	always_comb begin
		plhf_pkg::result_t r;
		r          = '0;
		state_d    = state_q;
		cur_gen_d  = cur_gen_q;
		owner_d    = owner_q;
		incoming_d = incoming_q;
		reserved_d = reserved_q;
		r.status   = plhf_pkg::RC_OK;

		unique case (func)
			plhf_pkg::FN_ACTIVATE: begin
				if (prod == '0) begin
					r.status = plhf_pkg::RC_ARG;
				end else if (state_q != plhf_pkg::ST_EMPTY) begin
					r.status = plhf_pkg::RC_STATE;
				end else begin
					cur_gen_d = gen_next;
					owner_d   = prod;
					state_d   = plhf_pkg::ST_ACTIVE;
					r.gen     = gen_next;
				end
			end
			plhf_pkg::FN_START_HANDOFF: begin
				if (prod == '0 || nxt == '0 || prod == nxt) begin
					r.status = plhf_pkg::RC_ARG;
				end else if (!pair_ok) begin
					r.status = plhf_pkg::RC_STATE;
				end else begin
					incoming_d = nxt;
					reserved_d = gen_next;
					state_d    = plhf_pkg::ST_HANDOFF;
				end
			end
			plhf_pkg::FN_COMMIT: begin
				if (nxt == '0) begin
					r.status = plhf_pkg::RC_ARG;
				end else if (state_q != plhf_pkg::ST_HANDOFF || incoming_q != nxt) begin
					r.status = plhf_pkg::RC_STATE;
				end else begin
					cur_gen_d  = reserved_q;
					owner_d    = nxt;
					incoming_d = '0;
					reserved_d = '0;
					state_d    = plhf_pkg::ST_ACTIVE;
					r.gen      = reserved_q;
				end
			end
			plhf_pkg::FN_ABORT: begin
				if (state_q == plhf_pkg::ST_HANDOFF) begin
					incoming_d = '0;
					reserved_d = '0;
					state_d    = plhf_pkg::ST_ACTIVE;
				end
			end
			plhf_pkg::FN_FAULT: begin
				incoming_d = '0;
				reserved_d = '0;
				state_d    = plhf_pkg::ST_FAULT;
			end
			plhf_pkg::FN_BEGIN_RECOVER: begin
				if (prod == '0) begin
					r.status = plhf_pkg::RC_ARG;
				end else if (state_q != plhf_pkg::ST_FAULT) begin
					r.status = plhf_pkg::RC_STATE;
				end else begin
					incoming_d = prod;
					reserved_d = gen_next;
					state_d    = plhf_pkg::ST_HANDOFF;
				end
			end
			plhf_pkg::FN_RECOVER: begin
				// Begin recover and commit collapse into one step: the
				// commit cannot fail once the recover has started.
				if (prod == '0) begin
					r.status = plhf_pkg::RC_ARG;
				end else if (state_q != plhf_pkg::ST_FAULT) begin
					r.status = plhf_pkg::RC_STATE;
				end else begin
					cur_gen_d  = gen_next;
					owner_d    = prod;
					incoming_d = '0;
					reserved_d = '0;
					state_d    = plhf_pkg::ST_ACTIVE;
					r.gen      = gen_next;
				end
			end
			plhf_pkg::FN_VALIDATE: begin
				r.is_valid = pair_ok;
			end
			default: begin
			end
		endcase

		r.lease_state = state_d;
		r.pending_gen = (state_d == plhf_pkg::ST_HANDOFF) ? reserved_d : '0;
		result        = r;
	end

endmodule

// ===== sv/producer_lease_handoff_fsm_core.sv =====
// Producer lease guard for a display output.
// One operation word goes in on the slave channel (s_*); one result word
// comes out on the master channel (m_*) for every operation, in order.
// s_tuser carries the operation code, s_tdata the producer ids and the
// presented generation. m_tdata carries status, committed generation,
// validity flag, lease state and pending generation.
// An accepted word waits in the input register, then passes through the
// lease logic into the result register that drives m_tvalid. Throughput
// is one word per cycle while m_tready stays high; the lease registers
// update as a word moves from the input register into the result
// register, so the next word sees the new state without a bubble.
// Reset puts the lease in the empty state with all ids and generations at
// zero and drops both valids. When the receiver holds m_tready low, the
// result register holds its word, the input register fills, and then
// s_tready falls until the result is taken.
module producer_lease_handoff_fsm_core #(
	parameter int PRODUCER_ID_BITS = plhf_pkg::PRODUCER_ID_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [plhf_pkg::S_DATA_W-1:0] s_tdata,  // producer, incoming producer, gen_in
	input  logic [plhf_pkg::FUNC_W-1:0]   s_tuser,  // func
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status, gen_out, is_valid, lease_state_out, pending_gen_out, zero pad
	output logic [plhf_pkg::M_DATA_W-1:0] m_tdata
);

	// Ids are compared on their low ID_W bits (PRODUCER_ID_BITS, at most 8) of the 8-bit field.
	localparam int ID_W = (PRODUCER_ID_BITS < plhf_pkg::ID_IN_W) ?
		PRODUCER_ID_BITS : plhf_pkg::ID_IN_W;
	localparam int RES_W = $bits(plhf_pkg::result_t);

	logic                          valid_s1;
	logic [plhf_pkg::FUNC_W-1:0]   func_s1;
	logic [ID_W-1:0]               prod_s1;
	logic [ID_W-1:0]               nxt_s1;
	logic [plhf_pkg::GEN_W-1:0]    gin_s1;

	logic                          valid_s2;
	plhf_pkg::result_t             result_s2;

	logic [plhf_pkg::STATE_W-1:0]  state_q;
	logic [plhf_pkg::GEN_W-1:0]    cur_gen_q;
	logic [ID_W-1:0]               owner_q;
	logic [ID_W-1:0]               incoming_q;
	logic [plhf_pkg::GEN_W-1:0]    reserved_q;

	logic [plhf_pkg::STATE_W-1:0]  state_d;
	logic [plhf_pkg::GEN_W-1:0]    cur_gen_d;
	logic [ID_W-1:0]               owner_d;
	logic [ID_W-1:0]               incoming_d;
	logic [plhf_pkg::GEN_W-1:0]    reserved_d;
	plhf_pkg::result_t             result;

	logic out_free;
	logic advance;
	logic take_in;

	assign out_free = !valid_s2 || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign take_in  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			func_s1 <= s_tuser;
			prod_s1 <= s_tdata[ID_W-1:0];
			nxt_s1  <= s_tdata[plhf_pkg::ID_IN_W +: ID_W];
			gin_s1  <= s_tdata[2*plhf_pkg::ID_IN_W +: plhf_pkg::GEN_W];
		end
	end

	plhf_step #(
		.ID_W(ID_W)
	) u_step (
		.func       (func_s1),
		.prod       (prod_s1),
		.nxt        (nxt_s1),
		.gin        (gin_s1),
		.state_q    (state_q),
		.cur_gen_q  (cur_gen_q),
		.owner_q    (owner_q),
		.incoming_q (incoming_q),
		.reserved_q (reserved_q),
		.state_d    (state_d),
		.cur_gen_d  (cur_gen_d),
		.owner_d    (owner_d),
		.incoming_d (incoming_d),
		.reserved_d (reserved_d),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= plhf_pkg::ST_EMPTY;
			cur_gen_q  <= '0;
			owner_q    <= '0;
			incoming_q <= '0;
			reserved_q <= '0;
		end else if (advance) begin
			state_q    <= state_d;
			cur_gen_q  <= cur_gen_d;
			owner_q    <= owner_d;
			incoming_q <= incoming_d;
			reserved_q <= reserved_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(plhf_pkg::M_DATA_W - RES_W){1'b0}}, result_s2};

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	localparam int ID_BITS     = plhf_pkg::PRODUCER_ID_BITS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_OPS  = 800;

	typedef struct {
		logic [plhf_pkg::FUNC_W-1:0]  func;
		logic [plhf_pkg::ID_IN_W-1:0] producer;
		logic [plhf_pkg::ID_IN_W-1:0] next_prod;
		logic [plhf_pkg::GEN_W-1:0]   gen_in;
	} lease_op_t;

	// Tracks the lease the way the block should and holds the results it owes.
	class lease_scoreboard;
		logic [plhf_pkg::STATE_W-1:0] lease;
		logic [plhf_pkg::GEN_W-1:0]   cur_gen;
		logic [plhf_pkg::ID_IN_W-1:0] owner;
		logic [plhf_pkg::ID_IN_W-1:0] incoming;
		logic [plhf_pkg::GEN_W-1:0]   resv_gen;
		plhf_pkg::result_t            owed_q[$];
		int                           errors;
		int                           checked;
		int                           op_count[8];
		int                           rc_count[3];

		function new();
			lease = plhf_pkg::ST_EMPTY;
			cur_gen = '0;
			owner = '0;
			incoming = '0;
			resv_gen = '0;
			errors = 0;
			checked = 0;
			foreach (op_count[i]) op_count[i] = 0;
			foreach (rc_count[i]) rc_count[i] = 0;
		endfunction

		function logic [plhf_pkg::ID_IN_W-1:0] trim_id(
				input logic [plhf_pkg::ID_IN_W-1:0] x);
			if (ID_BITS >= plhf_pkg::ID_IN_W)
				return x;
			return x & plhf_pkg::ID_IN_W'((1 << ID_BITS) - 1);
		endfunction

		// Zero is never a valid generation, so the count jumps over it on wrap.
		function logic [plhf_pkg::GEN_W-1:0] bump_gen(input logic [plhf_pkg::GEN_W-1:0] g);
			if (g == {plhf_pkg::GEN_W{1'b1}})
				return plhf_pkg::GEN_W'(1);
			return g + plhf_pkg::GEN_W'(1);
		endfunction

		function bit holds_authority(input logic [plhf_pkg::ID_IN_W-1:0] who,
				input logic [plhf_pkg::GEN_W-1:0] g);
			if (who == '0)
				return 1'b0;
			if (lease == plhf_pkg::ST_ACTIVE)
				return owner == who && cur_gen == g;
			if (lease == plhf_pkg::ST_HANDOFF)
				return incoming == who && resv_gen == g;
			return 1'b0;
		endfunction

		function logic [plhf_pkg::STATUS_W-1:0] open_recovery(
				input logic [plhf_pkg::ID_IN_W-1:0] who);
			if (who == '0)
				return plhf_pkg::RC_ARG;
			if (lease != plhf_pkg::ST_FAULT)
				return plhf_pkg::RC_STATE;
			incoming = who;
			resv_gen = bump_gen(cur_gen);
			lease = plhf_pkg::ST_HANDOFF;
			return plhf_pkg::RC_OK;
		endfunction

		function logic [plhf_pkg::STATUS_W-1:0] take_over(
				input logic [plhf_pkg::ID_IN_W-1:0] who,
				inout logic [plhf_pkg::GEN_W-1:0] g);
			if (who == '0)
				return plhf_pkg::RC_ARG;
			if (lease != plhf_pkg::ST_HANDOFF || incoming != who)
				return plhf_pkg::RC_STATE;
			cur_gen = resv_gen;
			owner = who;
			incoming = '0;
			resv_gen = '0;
			lease = plhf_pkg::ST_ACTIVE;
			g = cur_gen;
			return plhf_pkg::RC_OK;
		endfunction

		function void note_op(input lease_op_t op);
			logic [plhf_pkg::ID_IN_W-1:0]  p;
			logic [plhf_pkg::ID_IN_W-1:0]  n;
			logic [plhf_pkg::STATUS_W-1:0] rc;
			logic [plhf_pkg::GEN_W-1:0]    g;
			logic                          v;
			plhf_pkg::result_t             r;
			p = trim_id(op.producer);
			n = trim_id(op.next_prod);
			rc = plhf_pkg::RC_OK;
			g = '0;
			v = 1'b0;
			case (op.func)
				plhf_pkg::FN_ACTIVATE: begin
					if (p == '0) begin
						rc = plhf_pkg::RC_ARG;
					end else if (lease != plhf_pkg::ST_EMPTY) begin
						rc = plhf_pkg::RC_STATE;
					end else begin
						cur_gen = bump_gen(cur_gen);
						owner = p;
						lease = plhf_pkg::ST_ACTIVE;
						g = cur_gen;
					end
				end
				plhf_pkg::FN_START_HANDOFF: begin
					if (p == '0 || n == '0 || p == n) begin
						rc = plhf_pkg::RC_ARG;
					end else if (!holds_authority(p, op.gen_in)) begin
						rc = plhf_pkg::RC_STATE;
					end else begin
						incoming = n;
						resv_gen = bump_gen(cur_gen);
						lease = plhf_pkg::ST_HANDOFF;
					end
				end
				plhf_pkg::FN_COMMIT: rc = take_over(n, g);
				plhf_pkg::FN_ABORT: begin
					if (lease == plhf_pkg::ST_HANDOFF) begin
						incoming = '0;
						resv_gen = '0;
						lease = plhf_pkg::ST_ACTIVE;
					end
				end
				plhf_pkg::FN_FAULT: begin
					incoming = '0;
					resv_gen = '0;
					lease = plhf_pkg::ST_FAULT;
				end
				plhf_pkg::FN_BEGIN_RECOVER: rc = open_recovery(p);
				plhf_pkg::FN_RECOVER: begin
					rc = open_recovery(p);
					if (rc == plhf_pkg::RC_OK)
						rc = take_over(p, g);
				end
				default: v = holds_authority(p, op.gen_in);
			endcase
			r.status = rc;
			r.gen = g;
			r.is_valid = v;
			r.lease_state = lease;
			r.pending_gen = (lease == plhf_pkg::ST_HANDOFF) ? resv_gen : '0;
			owed_q.push_back(r);
			op_count[op.func]++;
			rc_count[rc]++;
		endfunction

		function void check_result(input logic [plhf_pkg::M_DATA_W-1:0] word);
			plhf_pkg::result_t got;
			plhf_pkg::result_t want;
			bit                bad;
			got = plhf_pkg::result_t'(word[$bits(plhf_pkg::result_t)-1:0]);
			if (owed_q.size() == 0) begin
				$display("%0t: result word with nothing expected: %h", $time, word);
				errors++;
				return;
			end
			want = owed_q.pop_front();
			checked++;
			bad = 1'b0;
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d got %0d", $time, want.status, got.status);
				bad = 1'b1;
			end
			if (got.gen !== want.gen) begin
				$display("%0t: gen_out expected %h got %h", $time, want.gen, got.gen);
				bad = 1'b1;
			end
			if (got.is_valid !== want.is_valid) begin
				$display("%0t: is_valid expected %0d got %0d", $time, want.is_valid,
					got.is_valid);
				bad = 1'b1;
			end
			if (got.lease_state !== want.lease_state) begin
				$display("%0t: lease_state expected %0d got %0d", $time, want.lease_state,
					got.lease_state);
				bad = 1'b1;
			end
			if (got.pending_gen !== want.pending_gen) begin
				$display("%0t: pending_gen expected %h got %h", $time, want.pending_gen,
					got.pending_gen);
				bad = 1'b1;
			end
			if (bad)
				errors++;
		endfunction

		function int pending();
			return owed_q.size();
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [plhf_pkg::S_DATA_W-1:0] s_tdata;
	logic [plhf_pkg::FUNC_W-1:0]   s_tuser;
	logic                          m_tvalid;
	logic                          m_tready;
	logic [plhf_pkg::M_DATA_W-1:0] m_tdata;

	lease_scoreboard sb;
	int              cycle_cnt;
	int              burst_left;
	int              rx_mode;
	int              mode_left;
	int              stall_left;

	producer_lease_handoff_fsm_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// The receiver switches between always ready, coin-flip ready and long stalls.
	always @(posedge clk) begin
		if (mode_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(30, 200);
		end
		mode_left--;
		case (rx_mode)
			0, 1: m_tready <= 1'b1;
			2: m_tready <= ($urandom_range(0, 1) == 1);
			default: begin
				if (stall_left > 0) begin
					stall_left--;
					m_tready <= 1'b0;
				end else if ($urandom_range(0, 9) == 0) begin
					stall_left = $urandom_range(1, 20);
					m_tready <= 1'b0;
				end else begin
					m_tready <= 1'b1;
				end
			end
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	function automatic lease_op_t mk_op(input logic [plhf_pkg::FUNC_W-1:0] f,
			input logic [plhf_pkg::ID_IN_W-1:0] p, input logic [plhf_pkg::ID_IN_W-1:0] n,
			input logic [plhf_pkg::GEN_W-1:0] g);
		lease_op_t op;
		op.func = f;
		op.producer = p;
		op.next_prod = n;
		op.gen_in = g;
		return op;
	endfunction

	// A nonzero id that differs from x.
	function automatic logic [plhf_pkg::ID_IN_W-1:0] other_id(
			input logic [plhf_pkg::ID_IN_W-1:0] x);
		int k;
		k = $urandom_range(1, 254);
		if (x == '0)
			return plhf_pkg::ID_IN_W'(k);
		return plhf_pkg::ID_IN_W'(((int'(x) - 1 + k) % 255) + 1);
	endfunction

	// Called at a rising edge; returns at the edge where the word was taken,
	// or after the idle gap that ends a burst.
	task automatic push_op(input lease_op_t op);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= op.func;
		s_tdata <= {op.gen_in, op.next_prod, op.producer};
		do @(posedge clk); while (!s_tready);
		sb.note_op(op);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 3);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) :
				$urandom_range(1, 16);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		lease_op_t                    op;
		logic [plhf_pkg::ID_IN_W-1:0] who;
		logic [plhf_pkg::GEN_W-1:0]   auth_gen;
		int                           k;

		sb = new();
		cycle_cnt = 0;
		burst_left = 1;
		rx_mode = 0;
		mode_left = 0;
		stall_left = 0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= plhf_pkg::FN_ACTIVATE;
		m_tready <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk through every operation and its error paths.
		push_op(mk_op(plhf_pkg::FN_VALIDATE, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
		push_op(mk_op(plhf_pkg::FN_ACTIVATE, 8'h00, 8'h12, 32'h0));
		push_op(mk_op(plhf_pkg::FN_START_HANDOFF, 8'h01, 8'h02, 32'h0));
		push_op(mk_op(plhf_pkg::FN_COMMIT, 8'h05, 8'h00, 32'h0));
		push_op(mk_op(plhf_pkg::FN_BEGIN_RECOVER, 8'h03, 8'h00, 32'h0));
		push_op(mk_op(plhf_pkg::FN_ABORT, 8'h00, 8'h00, 32'h0));
		push_op(mk_op(plhf_pkg::FN_ACTIVATE, 8'hFF, 8'h00, 32'h0));
		push_op(mk_op(plhf_pkg::FN_ACTIVATE, 8'h01, 8'h00, 32'h0));
		push_op(mk_op(plhf_pkg::FN_VALIDATE, 8'hFF, 8'h00, 32'h1));
		push_op(mk_op(plhf_pkg::FN_VALIDATE, 8'h00, 8'h00, 32'h1));
		push_op(mk_op(plhf_pkg::FN_START_HANDOFF, 8'hFF, 8'hFF, 32'h1));
		push_op(mk_op(plhf_pkg::FN_START_HANDOFF, 8'hFF, 8'h01, 32'hFFFF_FFFF));
		push_op(mk_op(plhf_pkg::FN_START_HANDOFF, 8'hFF, 8'h01, 32'h1));
		// A handoff may be restarted by the incoming producer.
		push_op(mk_op(plhf_pkg::FN_START_HANDOFF, 8'h01, 8'h80, 32'h2));
		push_op(mk_op(plhf_pkg::FN_COMMIT, 8'h00, 8'h7F, 32'h0));
		push_op(mk_op(plhf_pkg::FN_COMMIT, 8'h00, 8'h80, 32'h0));
		push_op(mk_op(plhf_pkg::FN_START_HANDOFF, 8'h80, 8'hAA, 32'h2));
		push_op(mk_op(plhf_pkg::FN_ABORT, 8'h00, 8'h00, 32'h0));
		push_op(mk_op(plhf_pkg::FN_FAULT, 8'h80, 8'h00, 32'h2));
		push_op(mk_op(plhf_pkg::FN_VALIDATE, 8'h80, 8'h00, 32'h2));
		push_op(mk_op(plhf_pkg::FN_RECOVER, 8'h00, 8'h00, 32'h0));
		push_op(mk_op(plhf_pkg::FN_BEGIN_RECOVER, 8'h55, 8'h00, 32'h0));
		push_op(mk_op(plhf_pkg::FN_COMMIT, 8'h00, 8'h55, 32'h0));
		push_op(mk_op(plhf_pkg::FN_FAULT, 8'h00, 8'h00, 32'h0));
		push_op(mk_op(plhf_pkg::FN_RECOVER, 8'hC3, 8'h00, 32'h0));
		push_op(mk_op(plhf_pkg::FN_RECOVER, 8'hC3, 8'h00, 32'h0));
		drain();

		// Mostly legal sequences driven from the tracked lease, some noise.
		for (int i = 0; i < RANDOM_OPS; i++) begin
			if (i == RANDOM_OPS / 2)
				drain();
			op = mk_op(plhf_pkg::FUNC_W'($urandom_range(0, 7)),
				plhf_pkg::ID_IN_W'($urandom), plhf_pkg::ID_IN_W'($urandom), $urandom);
			if ($urandom_range(0, 99) >= 15) begin
				who = (sb.lease == plhf_pkg::ST_HANDOFF) ? sb.incoming : sb.owner;
				auth_gen = (sb.lease == plhf_pkg::ST_HANDOFF) ? sb.resv_gen : sb.cur_gen;
				k = $urandom_range(0, 9);
				case (sb.lease)
					plhf_pkg::ST_EMPTY: begin
						op.func = (k < 7) ? plhf_pkg::FN_ACTIVATE : plhf_pkg::FN_VALIDATE;
						op.producer = plhf_pkg::ID_IN_W'($urandom_range(1, 255));
					end
					plhf_pkg::ST_ACTIVE: begin
						if (k < 5) begin
							op = mk_op(plhf_pkg::FN_START_HANDOFF, who, other_id(who),
								auth_gen);
						end else if (k == 5) begin
							op = mk_op(plhf_pkg::FN_VALIDATE, who, op.next_prod, auth_gen);
						end else if (k == 6) begin
							op.func = plhf_pkg::FN_FAULT;
						end else if (k == 7) begin
							op.func = plhf_pkg::FN_ABORT;
						end else if (k == 8) begin
							op.func = plhf_pkg::FN_ACTIVATE;
						end else begin
							op.func = plhf_pkg::FN_COMMIT;
							op.next_prod = other_id(who);
						end
					end
					plhf_pkg::ST_HANDOFF: begin
						if (k < 4) begin
							op.func = plhf_pkg::FN_COMMIT;
							op.next_prod = who;
						end else if (k == 4) begin
							op.func = plhf_pkg::FN_ABORT;
						end else if (k == 5) begin
							op = mk_op(plhf_pkg::FN_START_HANDOFF, who, other_id(who),
								auth_gen);
						end else if (k == 6) begin
							op = mk_op(plhf_pkg::FN_VALIDATE, who, op.next_prod, auth_gen);
						end else if (k == 7) begin
							op.func = plhf_pkg::FN_FAULT;
						end else if (k == 8) begin
							op.func = plhf_pkg::FN_COMMIT;
							op.next_prod = other_id(who);
						end else begin
							op.func = plhf_pkg::FN_RECOVER;
						end
					end
					default: begin
						if (k < 4) begin
							op.func = plhf_pkg::FN_RECOVER;
							op.producer = plhf_pkg::ID_IN_W'($urandom_range(1, 255));
						end else if (k < 7) begin
							op.func = plhf_pkg::FN_BEGIN_RECOVER;
							op.producer = plhf_pkg::ID_IN_W'($urandom_range(1, 255));
						end else if (k == 7) begin
							op = mk_op(plhf_pkg::FN_VALIDATE, sb.owner, op.next_prod,
								sb.cur_gen);
						end else if (k == 8) begin
							op.func = plhf_pkg::FN_ACTIVATE;
						end else begin
							op.func = plhf_pkg::FN_ABORT;
						end
					end
				endcase
				// Occasionally a stale or corrupted generation.
				if ($urandom_range(0, 9) == 0)
					op.gen_in = op.gen_in ^
						(plhf_pkg::GEN_W'(1) << $urandom_range(0, plhf_pkg::GEN_W - 1));
			end
			push_op(op);
		end

		drain();
		repeat (10) @(posedge clk);
		$write("run covered activate %0d, handoff start %0d, commit %0d, abort %0d,",
			sb.op_count[plhf_pkg::FN_ACTIVATE], sb.op_count[plhf_pkg::FN_START_HANDOFF],
			sb.op_count[plhf_pkg::FN_COMMIT], sb.op_count[plhf_pkg::FN_ABORT]);
		$display(" fault %0d, recovery start %0d, recover %0d, validate %0d",
			sb.op_count[plhf_pkg::FN_FAULT], sb.op_count[plhf_pkg::FN_BEGIN_RECOVER],
			sb.op_count[plhf_pkg::FN_RECOVER], sb.op_count[plhf_pkg::FN_VALIDATE]);
		$display("  %0d results checked: %0d ok, %0d bad argument, %0d wrong state",
			sb.checked, sb.rc_count[plhf_pkg::RC_OK], sb.rc_count[plhf_pkg::RC_ARG],
			sb.rc_count[plhf_pkg::RC_STATE]);
		if (sb.errors == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
